// ===== design/hds_pkg.sv =====
// shared types, widths and constants of the heat diffusion stencil
// used by every module of the block; depends on nothing
package hds_pkg;

    localparam int TEMP_W     = 24;
    localparam int COEF_W     = 16;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int LAP_W      = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 11;
    localparam int TDATA_W    = 48;

    localparam int NUM_SLOTS  = 3;
    // slot order is emission order
    localparam int SLOT_DIAG  = 0;
    localparam int SLOT_EDGE  = 1;
    localparam int SLOT_CUR   = 2;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = 3;
    localparam int OUTQ_CW    = 4;
    // room kept for runs still in the pipeline
    localparam int OUTQ_ROOM  = 4;

    localparam logic [COEF_W-1:0] COEF_RST = 16'd16384;
    localparam logic [31:0]       ROWS_RST = 32'd256;
    localparam logic [31:0]       COLS_RST = 32'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF = 2'd0,
        REG_ROWS  = 2'd1,
        REG_COLS  = 2'd2
    } cfg_reg_t;

    typedef logic signed [TEMP_W-1:0] temp_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        temp_t                temp;
        logic                 last;
        logic                 eof;
    } slot_t;

    typedef struct packed {
        slot_t [NUM_SLOTS-1:0] slot;
        logic  [NUM_SLOTS-1:0] mask;
    } group_t;

    typedef struct packed {
        logic signed [LAP_W-1:0] lap;
        temp_t                   ctr;
        logic                    en;
    } stencil_t;

    // clamp a grid size to 3..vmax and return the last index
    function automatic logic [31:0] clamp_last(input logic [31:0] v, input logic [31:0] vmax);
        logic [31:0] c;
        c = v;
        if (c < 32'd3)
        begin
            c = 32'd3;
        end
        if (c > vmax)
        begin
            c = vmax;
        end
        return c - 32'd1;
    endfunction

endpackage

// ===== design/hds_window.sv =====
// line buffers, 3x3 window and result slot builder of the stencil
// depends on hds_pkg
module hds_window
    import hds_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  temp_t                        in_temp,
    input  logic [$clog2(MAX_ROWS)-1:0]  in_row,
    input  logic [$clog2(MAX_COLS)-1:0]  in_col,
    input  logic                         in_lastcol,
    input  logic                         in_lastrow,
    input  logic [$clog2(MAX_COLS)-1:0]  col_last,
    output stencil_t                     st,
    output group_t                       grp,
    output logic                         grp_valid
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    temp_t mem_above [MAX_COLS];
    temp_t mem_two   [MAX_COLS];

    logic          s1_valid_reg;
    temp_t         x_s1_reg;
    logic [RW-1:0] row_s1_reg;
    logic [CW-1:0] col_s1_reg;
    logic          lastcol_s1_reg;
    logic          lastrow_s1_reg;
    temp_t         rd_above_reg;
    temp_t         rd_two_reg;
    logic          fwd_hit_reg;
    temp_t         fwd_above_reg;
    temp_t         fwd_two_reg;

    temp_t win_up_reg;
    temp_t win_ctr_reg;
    temp_t win_dn_reg;
    temp_t win_left_reg;

    stencil_t st_reg;
    group_t   grp_reg;
    logic     grp_valid_reg;

    temp_t    t1;
    temp_t    t2;
    stencil_t st_next;
    group_t   grp_next;

    // line buffers: read at accept, written in the cycle after
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rd_above_reg <= mem_above[in_col];
            rd_two_reg   <= mem_two[in_col];
        end
        if (s1_valid_reg)
        begin
            mem_above[col_s1_reg] <= x_s1_reg;
            mem_two[col_s1_reg]   <= t1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            grp_valid_reg <= 1'b0;
            win_up_reg    <= '0;
            win_ctr_reg   <= '0;
            win_dn_reg    <= '0;
            win_left_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            // same column written in this cycle: read returns stale data
            fwd_hit_reg   <= in_valid && s1_valid_reg && (in_col == col_s1_reg);
            grp_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                win_up_reg   <= t2;
                win_ctr_reg  <= t1;
                win_dn_reg   <= x_s1_reg;
                win_left_reg <= win_ctr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            x_s1_reg       <= in_temp;
            row_s1_reg     <= in_row;
            col_s1_reg     <= in_col;
            lastcol_s1_reg <= in_lastcol;
            lastrow_s1_reg <= in_lastrow;
        end
        fwd_above_reg <= x_s1_reg;
        fwd_two_reg   <= t1;
        st_reg        <= st_next;
        grp_reg       <= grp_next;
    end

    always_comb
    begin
        logic          r_nz;
        logic [RW-1:0] r_m1;
        t1 = fwd_hit_reg ? fwd_above_reg : rd_above_reg;
        t2 = fwd_hit_reg ? fwd_two_reg   : rd_two_reg;
        r_nz = (row_s1_reg != '0);
        r_m1 = row_s1_reg - RW'(1);

        st_next.lap = LAP_W'(win_left_reg) + LAP_W'(t1) + LAP_W'(win_up_reg)
                    + LAP_W'(win_dn_reg) - (LAP_W'(win_ctr_reg) <<< 2);
        st_next.ctr = win_ctr_reg;
        st_next.en  = (row_s1_reg > RW'(1)) && (col_s1_reg > CW'(1))
                    && (col_s1_reg <= col_last);

        grp_next.mask[SLOT_DIAG]      = r_nz && (col_s1_reg != '0);
        grp_next.slot[SLOT_DIAG].row  = ROW_OUT_W'(r_m1);
        grp_next.slot[SLOT_DIAG].col  = COL_OUT_W'(col_s1_reg - CW'(1));
        grp_next.slot[SLOT_DIAG].temp = win_ctr_reg;
        grp_next.slot[SLOT_DIAG].eof  = 1'b0;

        grp_next.mask[SLOT_EDGE]      = r_nz && lastcol_s1_reg;
        grp_next.slot[SLOT_EDGE].row  = ROW_OUT_W'(r_m1);
        grp_next.slot[SLOT_EDGE].col  = COL_OUT_W'(col_s1_reg);
        grp_next.slot[SLOT_EDGE].temp = t1;
        grp_next.slot[SLOT_EDGE].eof  = 1'b0;

        grp_next.mask[SLOT_CUR]       = !r_nz || lastrow_s1_reg;
        grp_next.slot[SLOT_CUR].row   = ROW_OUT_W'(row_s1_reg);
        grp_next.slot[SLOT_CUR].col   = COL_OUT_W'(col_s1_reg);
        grp_next.slot[SLOT_CUR].temp  = x_s1_reg;
        grp_next.slot[SLOT_CUR].eof   = lastrow_s1_reg && lastcol_s1_reg;

        // last word of the run is the highest slot present
        grp_next.slot[SLOT_CUR].last  = grp_next.mask[SLOT_CUR];
        grp_next.slot[SLOT_EDGE].last = grp_next.mask[SLOT_EDGE] && !grp_next.mask[SLOT_CUR];
        grp_next.slot[SLOT_DIAG].last = grp_next.mask[SLOT_DIAG] && !grp_next.mask[SLOT_EDGE]
                                      && !grp_next.mask[SLOT_CUR];
    end

    assign st        = st_reg;
    assign grp       = grp_reg;
    assign grp_valid = grp_valid_reg;

    a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> $past(s1_valid_reg) && $past(in_valid))
        else $error("line buffer forward without a write in flight");

    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> $onehot0({grp_reg.slot[SLOT_CUR].last,
                                    grp_reg.slot[SLOT_EDGE].last,
                                    grp_reg.slot[SLOT_DIAG].last}))
        else $error("more than one last word in a run");

endmodule

// ===== design/hds_arith.sv =====
// stencil update: coefficient multiply with rounding, then add and saturate
// depends on hds_pkg
module hds_arith
    import hds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [COEF_W-1:0] coeff,
    input  stencil_t          st,
    input  group_t            grp_in,
    input  logic              grp_in_valid,
    output group_t            grp_out,
    output logic              push
);

    localparam int PROD_W = COEF_W + 1 + LAP_W;
    localparam int Q_W    = PROD_W - COEF_W;
    localparam int SUM_W  = Q_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [Q_W-1:0]    q_next;
    logic signed [SUM_W-1:0]  sum;
    temp_t                    sat_val;

    logic signed [Q_W-1:0] q_reg;
    temp_t                 ctr_reg;
    logic                  en_reg;
    group_t                grp_reg;
    logic                  valid_reg;

    always_comb
    begin
        prod   = $signed({1'b0, coeff}) * st.lap + PROD_W'(32768);
        // floor of the rounded product, dropping the 16 fraction bits of the Q0.16 coefficient
        q_next = prod[PROD_W-1:COEF_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= grp_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        ctr_reg <= st.ctr;
        en_reg  <= st.en;
        grp_reg <= grp_in;
    end

    always_comb
    begin
        sum = SUM_W'(ctr_reg) + SUM_W'(q_reg);
        if (sum[SUM_W-1:TEMP_W-1] == '0 || sum[SUM_W-1:TEMP_W-1] == '1)
        begin
            sat_val = sum[TEMP_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat_val = {1'b1, {(TEMP_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(TEMP_W-1){1'b1}}};
        end

        grp_out = grp_reg;
        if (en_reg)
        begin
            grp_out.slot[SLOT_DIAG].temp = sat_val;
        end
    end

    assign push = valid_reg && (grp_reg.mask != '0);

endmodule

// ===== design/hds_outq.sv =====
// result queue of up to three words per cell, serializer and output register
// depends on hds_pkg
module hds_outq
    import hds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  group_t             push_grp,
    output logic [OUTQ_CW-1:0] count,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // out_row, out_col, new_temp, zero pad
    output logic               m_axis_tlast,  // last_of_run
    output logic               m_axis_tuser   // end_of_frame
);

    group_t fifo_mem [OUTQ_DEPTH];

    logic [OUTQ_AW-1:0]   wr_ptr_reg;
    logic [OUTQ_AW-1:0]   rd_ptr_reg;
    logic [OUTQ_CW-1:0]   count_reg;
    logic [OUTQ_CW-1:0]   count_next;
    logic [NUM_SLOTS-1:0] done_reg;
    logic [NUM_SLOTS-1:0] done_next;
    logic                 m_valid_reg;
    slot_t                m_slot_reg;

    group_t               head;
    logic [NUM_SLOTS-1:0] rem;
    logic [NUM_SLOTS-1:0] pick;
    logic                 load;
    logic                 pop;
    slot_t                pick_slot;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_grp;
        end
        if (load)
        begin
            m_slot_reg <= pick_slot;
        end
    end

    always_comb
    begin
        head = fifo_mem[rd_ptr_reg];
        rem  = head.mask & ~done_reg;
        // lowest pending slot goes first
        pick = rem & (~rem + NUM_SLOTS'(1));
        pick_slot = head.slot[SLOT_CUR];
        if (pick[SLOT_DIAG])
        begin
            pick_slot = head.slot[SLOT_DIAG];
        end
        else if (pick[SLOT_EDGE])
        begin
            pick_slot = head.slot[SLOT_EDGE];
        end
        load = (count_reg != '0) && (!m_valid_reg || m_axis_tready);
        pop  = load && ((rem & ~pick) == '0);
        done_next = done_reg;
        if (pop)
        begin
            done_next = '0;
        end
        else if (load)
        begin
            done_next = done_reg | pick;
        end
        count_next = count_reg + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_AW'(1);
            end
            count_reg <= count_next;
            done_reg  <= done_next;
            if (load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign count         = count_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - TEMP_W - COL_OUT_W - ROW_OUT_W){1'b0}},
                            m_slot_reg.temp, m_slot_reg.col, m_slot_reg.row};
    assign m_axis_tlast  = m_slot_reg.last;
    assign m_axis_tuser  = m_slot_reg.eof;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != OUTQ_CW'(OUTQ_DEPTH)) || pop)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("result queue count out of range");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (rem != '0))
        else $error("queued run with no word left");

endmodule

// ===== design/heat_diffusion_stencil_5pt.sv =====
// top level of the five-point heat diffusion stencil: config, position counters
// depends on hds_pkg, hds_window, hds_arith, hds_outq
//
// cells stream in on s_axis in raster order, one word per cell; tuser marks
// row 0, column 0 and restarts the position at once. results leave on m_axis,
// each carrying its row and column; tlast closes the words caused by one cell
// and tuser flags the grid's final cell. a cell causes zero to three words.
// the config channel takes a register index and data; it is always ready and
// must only be written while the block is idle.
// throughput: one cell per cycle while s_axis_tready is high, set by the
// single read and write port pair of the two line buffers. a word passes the
// input register, the window stage, the multiply stage, add and saturate into
// the result queue, and the output register. row ends after row 0 produce two
// or three words; an eight run queue soaks those up. s_axis_tready drops only
// when more than four runs are queued, so when the receiver stalls, words wait
// in the queue and the input stops. reset clears counters, window and queue
// and loads coefficient 16384 and a 256 x 256 grid; line buffer contents are
// unknown until the first two rows of a frame have passed.
module heat_diffusion_stencil_5pt
    import hds_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TEMP_W-1:0]     s_axis_tdata,  // cell_temp
    input  logic                  s_axis_tuser,  // start_of_frame
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,  // out_row, out_col, new_temp, zero pad
    output logic                  m_axis_tlast,  // last_of_run
    output logic                  m_axis_tuser,  // end_of_frame
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam logic [31:0] ROW_LAST_RST = clamp_last(ROWS_RST, 32'(MAX_ROWS));
    localparam logic [31:0] COL_LAST_RST = clamp_last(COLS_RST, 32'(MAX_COLS));

    logic [COEF_W-1:0] coeff_reg;
    logic [RW-1:0]     row_last_reg;
    logic [CW-1:0]     col_last_reg;
    logic [RW-1:0]     row_cnt_reg;
    logic [CW-1:0]     col_cnt_reg;
    logic [RW-1:0]     row_cnt_next;
    logic [CW-1:0]     col_cnt_next;

    logic          accept;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic          cur_lastcol;
    logic          cur_lastrow;

    stencil_t           st;
    group_t             win_grp;
    logic               win_grp_valid;
    group_t             arith_grp;
    logic               push;
    logic [OUTQ_CW-1:0] outq_count;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (outq_count <= OUTQ_CW'(OUTQ_DEPTH - OUTQ_ROOM));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cur_row     = s_axis_tuser ? '0 : row_cnt_reg;
        cur_col     = s_axis_tuser ? '0 : col_cnt_reg;
        cur_lastcol = (cur_col >= col_last_reg);
        cur_lastrow = (cur_row >= row_last_reg);
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (accept)
        begin
            if (cur_lastcol)
            begin
                col_cnt_next = '0;
                row_cnt_next = cur_lastrow ? '0 : cur_row + RW'(1);
            end
            else
            begin
                col_cnt_next = cur_col + CW'(1);
                row_cnt_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg    <= COEF_RST;
            row_last_reg <= RW'(ROW_LAST_RST);
            col_last_reg <= CW'(COL_LAST_RST);
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_COEFF:
                    begin
                        coeff_reg <= cfg_data[COEF_W-1:0];
                    end
                    REG_ROWS:
                    begin
                        row_last_reg <= RW'(clamp_last(32'(cfg_data[ROWS_CFG_W-1:0]),
                                                       32'(MAX_ROWS)));
                    end
                    REG_COLS:
                    begin
                        col_last_reg <= CW'(clamp_last(32'(cfg_data[COLS_CFG_W-1:0]),
                                                       32'(MAX_COLS)));
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    hds_window #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_temp    (s_axis_tdata),
        .in_row     (cur_row),
        .in_col     (cur_col),
        .in_lastcol (cur_lastcol),
        .in_lastrow (cur_lastrow),
        .col_last   (col_last_reg),
        .st         (st),
        .grp        (win_grp),
        .grp_valid  (win_grp_valid)
    );

    hds_arith u_arith (
        .clk          (clk),
        .rst_n        (rst_n),
        .coeff        (coeff_reg),
        .st           (st),
        .grp_in       (win_grp),
        .grp_in_valid (win_grp_valid),
        .grp_out      (arith_grp),
        .push         (push)
    );

    hds_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_grp      (arith_grp),
        .count         (outq_count),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== test/heat_diffusion_stencil_5pt_test.sv =====
// self-checking testbench for heat_diffusion_stencil_5pt: streams grid frames, predicts
// every result word from its own stencil model and compares them in order
// depends on hds_pkg and the heat_diffusion_stencil_5pt design files
module heat_diffusion_stencil_5pt_test;
    import hds_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 4096;
    localparam int RANDOM_ITEMS  = 265;
    localparam int LATENCY_PAUSE = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int COL_LO        = ROW_OUT_W;
    localparam int TEMP_LO       = ROW_OUT_W + COL_OUT_W;
    localparam temp_t TEMP_MAX   = 24'h7FFFFF;
    localparam temp_t TEMP_MIN   = 24'h800000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TEMP_W-1:0]     s_axis_tdata = '0;   // cell_temp
    logic                  s_axis_tuser = 1'b0; // start_of_frame
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [TDATA_W-1:0]    m_axis_tdata;        // out_row, out_col, new_temp, zero pad
    logic                  m_axis_tlast;        // last_of_run
    logic                  m_axis_tuser;        // end_of_frame
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // grid model state
    temp_t                 row_above [MAX_COLS];
    temp_t                 row_two_above [MAX_COLS];
    temp_t                 win [6];
    int unsigned           pos_row;
    int unsigned           pos_col;
    logic [COEF_W-1:0]     coeff_q;
    logic [ROWS_CFG_W-1:0] rows_q;
    logic [COLS_CFG_W-1:0] cols_q;

    slot_t                 due_cells [$];
    slot_t                 seen;
    slot_t                 want;
    int                    bad_words = 0;
    int                    sink_hold = 0;
    int                    cycles = 0;
    bit                    src_free = 1'b0;
    bit                    sink_free = 1'b0;

    heat_diffusion_stencil_5pt dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic temp_t diffuse(temp_t ctr, temp_t lf, temp_t rt, temp_t up, temp_t dn);
        longint lap;
        longint prod;
        longint sum;
        lap  = longint'(lf) + longint'(rt) + longint'(up) + longint'(dn) - 4 * longint'(ctr);
        prod = longint'(coeff_q) * lap + 32768;
        // arithmetic shift floors, so the half added above rounds ties upward
        sum  = longint'(ctr) + (prod >>> 16);
        if (sum > longint'(TEMP_MAX))
        begin
            return TEMP_MAX;
        end
        if (sum < longint'(TEMP_MIN))
        begin
            return TEMP_MIN;
        end
        return temp_t'(sum);
    endfunction

    function automatic slot_t word_of(int unsigned r, int unsigned c, temp_t v, logic eof);
        slot_t w;
        w.row  = r[ROW_OUT_W-1:0];
        w.col  = c[COL_OUT_W-1:0];
        w.temp = v;
        w.last = 1'b0;
        w.eof  = eof;
        return w;
    endfunction

    task automatic step_grid(input temp_t x, input logic sof);
        int unsigned rows_n;
        int unsigned cols_n;
        int unsigned r;
        int unsigned c;
        bit          lastcol;
        bit          lastrow;
        temp_t       t1;
        temp_t       t2;
        temp_t       v;
        slot_t       words [3];
        int          n;
        rows_n = 32'(rows_q);
        cols_n = 32'(cols_q);
        if (rows_n < 3)
        begin
            rows_n = 3;
        end
        if (rows_n > MAX_ROWS)
        begin
            rows_n = MAX_ROWS;
        end
        if (cols_n < 3)
        begin
            cols_n = 3;
        end
        if (cols_n > MAX_COLS)
        begin
            cols_n = MAX_COLS;
        end
        if (sof)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        lastcol = c >= cols_n - 1;
        lastrow = r >= rows_n - 1;
        t2 = row_two_above[c];
        t1 = row_above[c];
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            v = win[1];
            // a column beyond the last one is passed, never computed
            if (r >= 2 && c >= 2 && c <= cols_n - 1)
            begin
                v = diffuse(win[1], win[4], t1, win[0], win[2]);
            end
            words[n] = word_of(r - 1, c - 1, v, 1'b0);
            n++;
        end
        if (r >= 1 && lastcol)
        begin
            words[n] = word_of(r - 1, c, t1, 1'b0);
            n++;
        end
        if (r == 0 || lastrow)
        begin
            words[n] = word_of(r, c, x, lastrow && lastcol);
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            words[i].last = (i == n - 1);
            due_cells.push_back(words[i]);
        end
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = t2;
        win[1] = t1;
        win[2] = x;
        row_two_above[c] = t1;
        row_above[c] = x;
        if (lastcol)
        begin
            pos_col = 0;
            pos_row = lastrow ? 0 : r + 1;
        end
        else
        begin
            pos_col = c + 1;
        end
    endtask

    // ---------------------------------------------------------------- result side

    assign seen = {m_axis_tdata[ROW_OUT_W-1:0], m_axis_tdata[TEMP_LO-1:COL_LO],
                   m_axis_tdata[TEMP_LO+TEMP_W-1:TEMP_LO], m_axis_tlast, m_axis_tuser};

    task automatic report_word(input string why, input slot_t exp_w, input slot_t got_w);
        bad_words++;
        if (bad_words <= 10)
        begin
            $display("%s at cycle %0d: expected row %0d col %0d temp %0d last %b eof %b,",
                     why, cycles, exp_w.row, exp_w.col, exp_w.temp, exp_w.last, exp_w.eof);
            $display("    got row %0d col %0d temp %0d last %b eof %b",
                     got_w.row, got_w.col, got_w.temp, got_w.last, got_w.eof);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_cells.size() == 0)
            begin
                report_word("word with nothing due", '0, seen);
            end
            else
            begin
                want = due_cells.pop_front();
                if (want.row !== seen.row || want.col !== seen.col || want.temp !== seen.temp
                    || want.last !== seen.last || want.eof !== seen.eof)
                begin
                    report_word("word mismatch", want, seen);
                end
            end
            sink_hold = sink_free ? 0 : $urandom_range(0, 4);
            if (sink_hold != 0)
            begin
                m_axis_tready <= 1'b0;
            end
        end
        else if (sink_hold != 0)
        begin
            sink_hold--;
            if (sink_hold == 0)
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // every task starts and ends on a rising edge
    task automatic send_cell(input temp_t x, input logic sof);
        int gap;
        gap = src_free ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= sof;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        step_grid(x, sof);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due_cells.size() != 0)
        begin
            @(posedge clk);
        end
        // cells that cause no word may still be in flight
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_COEFF: coeff_q = val;
            REG_ROWS:  rows_q = val[ROWS_CFG_W-1:0];
            REG_COLS:  cols_q = val[COLS_CFG_W-1:0];
            default:   ;
        endcase
        @(posedge clk);
    endtask

    function automatic temp_t draw_temp();
        case ($urandom_range(0, 9))
            0:       return TEMP_MAX;
            1:       return TEMP_MIN;
            2, 3, 4: return temp_t'($urandom);
            default: return temp_t'(int'($urandom_range(0, 65535)) - 32768);
        endcase
    endfunction

    // position and coefficient straight out of reset, 256 x 256 grid
    task automatic test_reset_defaults();
        for (int i = 0; i < 3; i++)
        begin
            send_cell(draw_temp(), 1'b0);
        end
        settle();
    endtask

    // 3 x 4 grid at the top coefficient: one interior cell saturates up, the other down
    task automatic test_saturation();
        temp_t cells [12] = '{24'sd0, TEMP_MAX, TEMP_MIN, 24'sd0,
                              TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN,
                              24'sd0, TEMP_MAX, TEMP_MIN, 24'sd0};
        write_reg(REG_ROWS, 16'd0);
        write_reg(REG_COLS, 16'd4);
        write_reg(REG_COEFF, 16'hFFFF);
        for (int i = 0; i < 12; i++)
        begin
            send_cell(cells[i], i == 0);
        end
        settle();
    endtask

    // shrink the grid mid-frame so the current column lies past the last one
    task automatic test_past_last_column();
        write_reg(REG_ROWS, 16'd3);
        write_reg(REG_COLS, 16'd5);
        write_reg(REG_COEFF, 16'd16384);
        for (int i = 0; i < 9; i++)
        begin
            send_cell(draw_temp(), i == 0);
        end
        settle();
        write_reg(REG_COLS, 16'd2);
        for (int i = 0; i < 4; i++)
        begin
            send_cell(draw_temp(), 1'b0);
        end
        settle();
    endtask

    // largest sizes and sizes past them, only the start of row 0
    task automatic test_largest_grid();
        write_reg(REG_ROWS, 16'(MAX_ROWS));
        write_reg(REG_COLS, 16'(MAX_COLS));
        for (int i = 0; i < 4; i++)
        begin
            send_cell(draw_temp(), i == 0);
        end
        settle();
        write_reg(REG_ROWS, 16'h1FFF);
        write_reg(REG_COLS, 16'h07FF);
        for (int i = 0; i < 3; i++)
        begin
            send_cell(draw_temp(), i == 0);
        end
        settle();
    endtask

    // whole frames of random size and content, some cut short by a new frame
    task automatic test_random_frames();
        int sent;
        int rows_n;
        int cols_n;
        int cut;
        bit mid_frame;
        sent = 0;
        mid_frame = 1'b1;
        rows_n = 3;
        cols_n = 3;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0 || $urandom_range(0, 2) == 0)
            begin
                settle();
                if ($urandom_range(0, 5) == 0)
                begin
                    rows_n = 3;
                    cols_n = $urandom_range(10, 40);
                end
                else
                begin
                    rows_n = $urandom_range(3, 6);
                    cols_n = $urandom_range(3, 9);
                end
                write_reg(REG_ROWS, 16'(rows_n));
                write_reg(REG_COLS, 16'(cols_n));
                case ($urandom_range(0, 4))
                    0:       write_reg(REG_COEFF, 16'd0);
                    1:       write_reg(REG_COEFF, 16'hFFFF);
                    2:       ;
                    default: write_reg(REG_COEFF, 16'($urandom_range(0, 65535)));
                endcase
            end
            src_free  = ($urandom_range(0, 3) == 0);
            sink_free = ($urandom_range(0, 3) == 0);
            cut = rows_n * cols_n;
            if ($urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(1, cut - 1);
            end
            for (int i = 0; i < cut; i++)
            begin
                // a finished frame leaves the position at the origin, so the mark is optional
                send_cell(draw_temp(), i == 0 && (mid_frame || $urandom_range(0, 1)));
            end
            mid_frame = (cut != rows_n * cols_n);
            sent += cut;
        end
        src_free  = 1'b0;
        sink_free = 1'b0;
    endtask

    initial
    begin
        foreach (row_above[i])
        begin
            row_above[i] = '0;
            row_two_above[i] = '0;
        end
        foreach (win[i])
        begin
            win[i] = '0;
        end
        pos_row = 0;
        pos_col = 0;
        coeff_q = COEF_RST;
        rows_q  = ROWS_RST[ROWS_CFG_W-1:0];
        cols_q  = COLS_RST[COLS_CFG_W-1:0];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_saturation();
        test_past_last_column();
        test_largest_grid();
        test_random_frames();
        settle();
        if (bad_words == 0 && due_cells.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
